FILE: src/hsvr_pkg.sv
// ----------------------------------------------------------------------------
// hsvr_pkg
// Shared types, constants and helpers for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvr_pkg;

    localparam int unsigned HueW      = 15;   // hue, degrees x 64
    localparam int unsigned FixW      = 9;    // fixed point, 256 = 1.0
    localparam int unsigned SectW     = 4;    // sector number 0..8
    localparam int unsigned CoarseW   = 7;    // hue / 256
    localparam int unsigned RemHiW    = 4;    // (hue mod 3840) / 256
    localparam int unsigned RemW      = 12;   // hue mod 3840
    localparam int unsigned FracW     = 8;    // fraction within sector
    localparam int unsigned RecipW    = 13;
    localparam int unsigned NumStages = 5;

    // One sector spans 60 degrees = 3840 hue units = 15 x 256
    localparam int unsigned SectMax   = 8;    // largest sector a 15-bit hue reaches
    localparam logic [CoarseW-1:0] SectCoarse = 7'd15;

    localparam logic [FixW-1:0] OneFix = 9'd256;

    // ceil(2^16 / 15): rem * Recip >> 16 == rem / 15 for rem < 3840
    localparam logic [RecipW-1:0] FracRecip = 13'd4370;

    // Colour wheel sectors; anything above takes the wrap-round arm
    localparam logic [SectW-1:0] SectRedYel = 4'd0;
    localparam logic [SectW-1:0] SectYelGrn = 4'd1;
    localparam logic [SectW-1:0] SectGrnCyn = 4'd2;
    localparam logic [SectW-1:0] SectCynBlu = 4'd3;
    localparam logic [SectW-1:0] SectBluMag = 4'd4;

    typedef logic [FixW-1:0] t_fix;

    typedef struct packed {
        logic [NumStages-1:0] vld;
        logic [NumStages-1:0] load;
    } t_pipe_ctl;

    function automatic t_fix sat_fix(input t_fix x);
        return (x > OneFix) ? OneFix : x;
    endfunction

    // Coarse hue (hue >> 8) divided by 15 via independent threshold compares
    function automatic logic [SectW-1:0] sector_of(input logic [CoarseW-1:0] coarse);
        logic [SectW-1:0] sect;
        sect = '0;
        for (int k = 1; k <= SectMax; k++) begin
            if ({1'b0, coarse} >= (CoarseW + 1)'(k * 15)) begin
                sect = SectW'(k);
            end
        end
        return sect;
    endfunction

endpackage

FILE: src/hsvr_in_if.sv
// ----------------------------------------------------------------------------
// hsvr_in_if
// HSV pixel channel: valid/ready handshake with hue, saturation, value.
// ----------------------------------------------------------------------------
interface hsvr_in_if;
    logic                        valid;
    logic                        ready;
    logic [hsvr_pkg::HueW-1:0]   hue;
    logic [hsvr_pkg::FixW-1:0]   saturation;
    logic [hsvr_pkg::FixW-1:0]   brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

FILE: src/hsvr_out_if.sv
// ----------------------------------------------------------------------------
// hsvr_out_if
// RGB pixel channel: valid/ready handshake with red, green, blue.
// ----------------------------------------------------------------------------
interface hsvr_out_if;
    logic                        valid;
    logic                        ready;
    logic [hsvr_pkg::FixW-1:0]   red;
    logic [hsvr_pkg::FixW-1:0]   green;
    logic [hsvr_pkg::FixW-1:0]   blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

FILE: src/hsvr_ctrl.sv
// ----------------------------------------------------------------------------
// hsvr_ctrl
// Stage valid bits and load enables; bubbles collapse, stalls ripple back.
// ----------------------------------------------------------------------------
module hsvr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output hsvr_pkg::t_pipe_ctl   o_ctl
);

    localparam int unsigned N = hsvr_pkg::NumStages;

    logic [N-1:0] r_vld;
    logic [N-1:0] n_vld;
    logic [N-1:0] rdy;

    always_comb begin
        rdy[N-1] = ~r_vld[N-1] | i_out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            rdy[k] = ~r_vld[k] | rdy[k+1];
        end
        n_vld[0] = rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < N; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready = rdy[0];
    assign o_ctl.vld  = r_vld;
    assign o_ctl.load = rdy;

endmodule

FILE: src/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Five-stage pipelined HSV to RGB colour conversion, one pixel per clock while o_pix is not stalled.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | beat payload
//  --------+-----+---------------------+----------------------------------
//  i_pix   | in  | valid / ready       | hue[14:0], saturation[8:0],
//          |     |                     | brightness[8:0]
//  o_pix   | out | valid / ready       | red[8:0], green[8:0], blue[8:0]
//
//  Accepted beats pass through the five register stages below to o_pix; one beat is
//  taken every cycle while o_pix.ready is high, as no stage then holds.
//  Each stage holds when the next one is full and stalled; empty stages fill
//  regardless, so bubbles close up and i_pix.ready only drops when all five
//  stages hold beats. Synchronous active-low reset clears the valid bits;
//  datapath registers are not reset.
//
//  Stages:
//   1  saturate s and v, sector = hue / 3840, remainder within sector
//   2  f = remainder / 15 by reciprocal multiply, 256 - s
//   3  s*f, s*(256-f), p = v*(256-s)
//   4  q = v*(256 - s*f), t = v*(256 - s*(256-f))
//   5  pick (r,g,b) by sector, grey when s is zero; output register
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hsvr_in_if.sink      i_pix,
    hsvr_out_if.source   o_pix
);

    localparam int unsigned FixW   = hsvr_pkg::FixW;
    localparam int unsigned SectW  = hsvr_pkg::SectW;
    localparam int unsigned RemW   = hsvr_pkg::RemW;
    localparam int unsigned FracW  = hsvr_pkg::FracW;
    localparam int unsigned RecipW = hsvr_pkg::RecipW;
    localparam int unsigned HueW   = hsvr_pkg::HueW;

    hsvr_pkg::t_pipe_ctl ctl;

    hsvr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_out_ready (o_pix.ready),
        .o_in_ready  (i_pix.ready),
        .o_ctl       (ctl)
    );

    // ---- stage 1: saturate, split hue into sector and remainder ------------
    logic [hsvr_pkg::CoarseW-1:0] coarse;
    logic [SectW-1:0]             sect_1;
    logic [hsvr_pkg::CoarseW-1:0] rem_hi_full;

    logic [SectW-1:0] r_sect_1;
    logic [RemW-1:0]  r_rem_1;
    logic [FixW-1:0]  r_s_1;
    logic [FixW-1:0]  r_v_1;

    always_comb begin
        coarse      = i_pix.hue[HueW-1:8];
        sect_1      = hsvr_pkg::sector_of(coarse);
        // 3840 = 15 x 256: remainder keeps the low byte of hue untouched
        rem_hi_full = coarse - hsvr_pkg::CoarseW'(sect_1 * hsvr_pkg::SectCoarse);
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[0]) begin
            r_sect_1 <= sect_1;
            r_rem_1  <= {rem_hi_full[hsvr_pkg::RemHiW-1:0], i_pix.hue[7:0]};
            r_s_1    <= hsvr_pkg::sat_fix(i_pix.saturation);
            r_v_1    <= hsvr_pkg::sat_fix(i_pix.brightness);
        end
    end

    // ---- stage 2: fraction within sector -----------------------------------
    logic [RemW+RecipW-1:0] frac_prod;

    logic [SectW-1:0] r_sect_2;
    logic [FracW-1:0] r_f_2;
    logic [FixW-1:0]  r_s_2;
    logic [FixW-1:0]  r_oms_2;   // 256 - s
    logic [FixW-1:0]  r_v_2;

    assign frac_prod = {{RecipW{1'b0}}, r_rem_1} * {{RemW{1'b0}}, hsvr_pkg::FracRecip};

    always_ff @(posedge i_clk) begin
        if (ctl.load[1]) begin
            r_sect_2 <= r_sect_1;
            r_f_2    <= frac_prod[16 +: FracW];
            r_s_2    <= r_s_1;
            r_oms_2  <= hsvr_pkg::OneFix - r_s_1;
            r_v_2    <= r_v_1;
        end
    end

    // ---- stage 3: s*f, s*(256-f), p ----------------------------------------
    logic [FixW-1:0]   omf;
    logic [2*FixW-1:0] sf_prod;
    logic [2*FixW-1:0] sg_prod;
    logic [2*FixW-1:0] p_prod;

    logic [SectW-1:0] r_sect_3;
    logic [FixW-1:0]  r_sf_3;
    logic [FixW-1:0]  r_sg_3;
    logic [FixW-1:0]  r_p_3;
    logic [FixW-1:0]  r_v_3;
    logic             r_grey_3;

    always_comb begin
        omf     = hsvr_pkg::OneFix - {1'b0, r_f_2};
        sf_prod = {{FixW{1'b0}}, r_s_2} * {{(FixW+1){1'b0}}, r_f_2};
        sg_prod = {{FixW{1'b0}}, r_s_2} * {{FixW{1'b0}}, omf};
        p_prod  = {{FixW{1'b0}}, r_v_2} * {{FixW{1'b0}}, r_oms_2};
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[2]) begin
            r_sect_3 <= r_sect_2;
            r_sf_3   <= sf_prod[8 +: FixW];
            r_sg_3   <= sg_prod[8 +: FixW];
            r_p_3    <= p_prod[8 +: FixW];
            r_v_3    <= r_v_2;
            r_grey_3 <= (r_s_2 == '0);
        end
    end

    // ---- stage 4: q and t --------------------------------------------------
    logic [2*FixW-1:0] q_prod;
    logic [2*FixW-1:0] t_prod;

    logic [SectW-1:0] r_sect_4;
    logic [FixW-1:0]  r_p_4;
    logic [FixW-1:0]  r_q_4;
    logic [FixW-1:0]  r_t_4;
    logic [FixW-1:0]  r_v_4;
    logic             r_grey_4;

    always_comb begin
        q_prod = {{FixW{1'b0}}, r_v_3} * {{FixW{1'b0}}, FixW'(hsvr_pkg::OneFix - r_sf_3)};
        t_prod = {{FixW{1'b0}}, r_v_3} * {{FixW{1'b0}}, FixW'(hsvr_pkg::OneFix - r_sg_3)};
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[3]) begin
            r_sect_4 <= r_sect_3;
            r_p_4    <= r_p_3;
            r_q_4    <= q_prod[8 +: FixW];
            r_t_4    <= t_prod[8 +: FixW];
            r_v_4    <= r_v_3;
            r_grey_4 <= r_grey_3;
        end
    end

    // ---- stage 5: sector select, output register ---------------------------
    logic [FixW-1:0] n_red;
    logic [FixW-1:0] n_green;
    logic [FixW-1:0] n_blue;

    logic [FixW-1:0] r_red;
    logic [FixW-1:0] r_green;
    logic [FixW-1:0] r_blue;

    always_comb begin
        unique case (r_sect_4)
            hsvr_pkg::SectRedYel: begin
                n_red = r_v_4;  n_green = r_t_4;  n_blue = r_p_4;
            end
            hsvr_pkg::SectYelGrn: begin
                n_red = r_q_4;  n_green = r_v_4;  n_blue = r_p_4;
            end
            hsvr_pkg::SectGrnCyn: begin
                n_red = r_p_4;  n_green = r_v_4;  n_blue = r_t_4;
            end
            hsvr_pkg::SectCynBlu: begin
                n_red = r_p_4;  n_green = r_q_4;  n_blue = r_v_4;
            end
            hsvr_pkg::SectBluMag: begin
                n_red = r_t_4;  n_green = r_p_4;  n_blue = r_v_4;
            end
            default: begin
                // magenta to red, and hue at or past 360 degrees
                n_red = r_v_4;  n_green = r_p_4;  n_blue = r_q_4;
            end
        endcase
        if (r_grey_4) begin
            n_red   = r_v_4;
            n_green = r_v_4;
            n_blue  = r_v_4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[4]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_pix.valid = ctl.vld[4];
    assign o_pix.red   = r_red;
    assign o_pix.green = r_green;
    assign o_pix.blue  = r_blue;

endmodule

FILE: src/hsvr_chk.sv
// ----------------------------------------------------------------------------
// hsvr_chk
// Port-level checks for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsvr_chk (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [hsvr_pkg::FixW-1:0]  i_sat,
    input  logic [hsvr_pkg::FixW-1:0]  i_bri,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [hsvr_pkg::FixW-1:0]  i_red,
    input  logic [hsvr_pkg::FixW-1:0]  i_green,
    input  logic [hsvr_pkg::FixW-1:0]  i_blue
);

    logic       in_acc;
    logic       clear_run;    // out ready at every edge in r_rdy_hist, no reset in r_rst_hist
    logic [3:0] r_rdy_hist;   // out ready history, newest edge in bit 0
    logic [4:0] r_rst_hist;   // reset line history, newest edge in bit 0

    assign in_acc = i_in_valid & i_in_ready;

    always_ff @(posedge i_clk) begin
        r_rdy_hist <= {r_rdy_hist[2:0], i_out_ready};
        r_rst_hist <= {r_rst_hist[3:0], i_rst_n};
    end

    assign clear_run = (&r_rdy_hist) && (&r_rst_hist);

    // stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // stalled result payload holds
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_red) && $stable(i_green) && $stable(i_blue))
        else $error("result payload changed while stalled");

    // accepted input beat yields a result when the output side has not stalled
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(in_acc, 5) && clear_run |-> i_out_valid)
        else $error("result missing five cycles after input beat");

    // zero saturation comes out grey at the clipped brightness
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(in_acc, 5) && clear_run && ($past(i_sat, 5) == '0) |->
            (i_red == hsvr_pkg::sat_fix($past(i_bri, 5)))
            && (i_green == i_red) && (i_blue == i_red))
        else $error("grey pixel not equal to brightness");

endmodule

bind hsv_to_rgb_converter hsvr_chk u_hsvr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_sat       (i_pix.saturation),
    .i_bri       (i_pix.brightness),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red),
    .i_green     (o_pix.green),
    .i_blue      (o_pix.blue)
);

FILE: tb/hsvr_pixel_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsvr_pixel_scoreboard
// Watches both pixel channels of the HSV to RGB converter. Every accepted
// HSV beat is turned into an expected RGB triple. Every accepted RGB beat
// is compared field by field with the oldest outstanding triple.
// ----------------------------------------------------------------------------
module hsvr_pixel_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsvr_in_if          i_hsv,
    hsvr_out_if         i_rgb,
    output int unsigned o_mismatches,
    output int unsigned o_pending
);

    localparam int unsigned HueW    = hsvr_pkg::HueW;
    localparam int unsigned HueSpan = 60 * 64;   // one sector in hue units

    typedef struct packed {
        hsvr_pkg::t_fix red;
        hsvr_pkg::t_fix green;
        hsvr_pkg::t_fix blue;
    } t_rgb_pixel;

    t_rgb_pixel  rgb_expected_q[$];
    int unsigned mismatch_count = 0;

    function automatic t_rgb_pixel hsv_to_rgb_expect(input logic [HueW-1:0] hue,
                                                     input hsvr_pkg::t_fix sat_in,
                                                     input hsvr_pkg::t_fix bri_in);
        int unsigned s, v, sector, frac, p_term, q_term, t_term;
        int unsigned red_v, grn_v, blu_v;
        t_rgb_pixel  px;
        s = (sat_in > hsvr_pkg::OneFix) ? int'(hsvr_pkg::OneFix) : int'(sat_in);
        v = (bri_in > hsvr_pkg::OneFix) ? int'(hsvr_pkg::OneFix) : int'(bri_in);
        if (s == 0) begin
            red_v = v;
            grn_v = v;
            blu_v = v;
        end else begin
            sector = hue / HueSpan;
            frac   = ((hue % HueSpan) * 256) / HueSpan;
            p_term = (v * (256 - s)) >> 8;
            q_term = (v * (256 - ((s * frac) >> 8))) >> 8;
            t_term = (v * (256 - ((s * (256 - frac)) >> 8))) >> 8;
            case (sector)
                hsvr_pkg::SectRedYel: begin
                    red_v = v;       grn_v = t_term;  blu_v = p_term;
                end
                hsvr_pkg::SectYelGrn: begin
                    red_v = q_term;  grn_v = v;       blu_v = p_term;
                end
                hsvr_pkg::SectGrnCyn: begin
                    red_v = p_term;  grn_v = v;       blu_v = t_term;
                end
                hsvr_pkg::SectCynBlu: begin
                    red_v = p_term;  grn_v = q_term;  blu_v = v;
                end
                hsvr_pkg::SectBluMag: begin
                    red_v = t_term;  grn_v = p_term;  blu_v = v;
                end
                default: begin
                    red_v = v;       grn_v = p_term;  blu_v = q_term;
                end
            endcase
        end
        px = '{red:   hsvr_pkg::t_fix'(red_v),
               green: hsvr_pkg::t_fix'(grn_v),
               blue:  hsvr_pkg::t_fix'(blu_v)};
        return px;
    endfunction

    always @(posedge i_clk) begin
        t_rgb_pixel want;
        if (i_rst_n) begin
            if (i_hsv.valid && i_hsv.ready) begin
                rgb_expected_q = {rgb_expected_q,
                    hsv_to_rgb_expect(i_hsv.hue, i_hsv.saturation, i_hsv.brightness)};
            end
            if (i_rgb.valid && i_rgb.ready) begin
                if (rgb_expected_q.size() == 0) begin
                    $error("rgb beat with nothing outstanding: %0d %0d %0d",
                           i_rgb.red, i_rgb.green, i_rgb.blue);
                    mismatch_count++;
                end else begin
                    want = rgb_expected_q.pop_front();
                    if (i_rgb.red !== want.red) begin
                        $error("red: expected %0d, actual %0d", want.red, i_rgb.red);
                        mismatch_count++;
                    end
                    if (i_rgb.green !== want.green) begin
                        $error("green: expected %0d, actual %0d", want.green, i_rgb.green);
                        mismatch_count++;
                    end
                    if (i_rgb.blue !== want.blue) begin
                        $error("blue: expected %0d, actual %0d", want.blue, i_rgb.blue);
                        mismatch_count++;
                    end
                end
            end
        end
        o_mismatches = mismatch_count;
        o_pending    = rgb_expected_q.size();
    end

endmodule

FILE: tb/hsv_to_rgb_converter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_test
// Stimulus and verdict for the HSV to RGB converter. A directed set of
// corner pixels is followed by about 2000 random ones, with random idle
// bursts on the input side and random stalls on the output side. A
// separate scoreboard predicts and checks every RGB beat.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test;

    localparam int unsigned    HueW        = hsvr_pkg::HueW;
    localparam hsvr_pkg::t_fix OneFix      = hsvr_pkg::OneFix;
    localparam int unsigned    HueSpan     = 60 * 64;  // hue units per sector
    localparam int unsigned    HueFull     = 360 * 64; // top of the legal range
    localparam int unsigned    RandomBeats = 2000;
    localparam int unsigned    QuietTail   = 300;     // last beats, no idling
    localparam int unsigned    DrainCycles = 20;      // well past the latency of the 5-stage pipeline

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        idle_on = 1'b0;   // enables gaps on i_pix and stalls on o_pix
    int unsigned mismatches;
    int unsigned pending;
    int unsigned stall_left = 0;

    hsvr_in_if  pix_in ();
    hsvr_out_if pix_out ();

    hsv_to_rgb_converter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    hsvr_pixel_scoreboard scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hsv        (pix_in),
        .i_rgb        (pix_out),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Output back-pressure: ready drops for bursts of random length while
    // idling is enabled. One assignment to ready per edge at most.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            if (stall_left == 0) begin
                pix_out.ready <= 1'b1;
            end
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            pix_out.ready <= 1'b0;
            stall_left = $urandom_range(1, 8);
        end
    end

    // One HSV beat. With idling on, an input gap of random length may come
    // first; valid is then raised with the payload and held until accepted.
    task automatic send_pixel(input logic [HueW-1:0] hue, input hsvr_pkg::t_fix sat,
                              input hsvr_pkg::t_fix bri);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.hue        <= hue;
        pix_in.saturation <= sat;
        pix_in.brightness <= bri;
        do @(posedge i_clk); while (!pix_in.ready);
    endtask

    // Random pixel: mostly inside the legal ranges, with a share of grey
    // pixels, exact unity values and out-of-range inputs that must clamp.
    task automatic send_random_pixel();
        logic [HueW-1:0] hue;
        hsvr_pkg::t_fix  sat;
        hsvr_pkg::t_fix  bri;
        hue = ($urandom_range(0, 9) == 0) ? HueW'($urandom) : HueW'($urandom_range(0, HueFull));
        case ($urandom_range(0, 7))
            0:       sat = '0;
            1:       sat = hsvr_pkg::t_fix'($urandom);
            2:       sat = OneFix;
            default: sat = hsvr_pkg::t_fix'($urandom_range(0, 256));
        endcase
        case ($urandom_range(0, 7))
            0:       bri = hsvr_pkg::t_fix'($urandom);
            1:       bri = OneFix;
            default: bri = hsvr_pkg::t_fix'($urandom_range(0, 256));
        endcase
        send_pixel(hue, sat, bri);
    endtask

    initial begin
        // every input known from time zero
        pix_in.valid      = 1'b0;
        pix_in.hue        = '0;
        pix_in.saturation = '0;
        pix_in.brightness = '0;
        pix_out.ready     = 1'b1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners, back to back
        send_pixel('0, OneFix, OneFix);                 // pure red
        send_pixel('0, '0, OneFix);                     // grey, zero saturation
        send_pixel(HueW'(12345), '0, 9'd100);           // grey at any hue
        send_pixel('0, OneFix, '0);                     // black
        // both sides of every sector boundary
        for (int k = 1; k <= 5; k++) begin
            send_pixel(HueW'(k * HueSpan - 1), OneFix, OneFix);
            send_pixel(HueW'(k * HueSpan), OneFix, OneFix);
        end
        send_pixel(HueW'(HueFull - 1), 9'd200, 9'd180); // just below 360
        send_pixel(HueW'(HueFull), OneFix, OneFix);     // exactly 360, wrap-round arm, comes out magenta
        send_pixel(HueW'(HueFull), 9'd1, 9'd255);
        send_pixel('1, OneFix, OneFix);                 // above 360, top sector
        send_pixel('1, '1, '1);                         // all ones, clamping
        send_pixel(HueW'(HueSpan / 2), 9'd257, 9'd300); // just over unity
        send_pixel(HueW'(7 * HueSpan / 2), 9'd1, 9'd1); // smallest non-zero
        send_pixel(HueW'(19000), 9'd255, 9'd256);

        // Random body: idling comes and goes in stretches of 200 beats,
        // and is off for the closing stretch.
        for (int n = 0; n < RandomBeats; n++) begin
            if (n >= RandomBeats - QuietTail) begin
                idle_on = 1'b0;
            end else if (n % 200 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            send_random_pixel();
        end
        pix_in.valid <= 1'b0;

        // drain the pipeline, then a few more cycles for any stray beat
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
src/hsvr_pkg.sv
src/hsvr_in_if.sv
src/hsvr_out_if.sv
src/hsvr_ctrl.sv
src/hsv_to_rgb_converter.sv
src/hsvr_chk.sv
tb/hsvr_pixel_scoreboard.sv
tb/hsv_to_rgb_converter_test.sv
